/* hw/rtl/psmh_pkg.sv */
// Shared types and constants for the priority set max-heap.
`timescale 1ns / 1ps

package psmh_pkg;

    localparam int PRIO_LEVELS = 256;
    localparam int LVL_W       = $clog2(PRIO_LEVELS);
    localparam int FILL_W      = LVL_W + 1;
    localparam int COUNT_BITS  = 10;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_SAT   = 2'd2
    } t_err;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LAST,
        ST_SD_A,
        ST_SD_B,
        ST_SD_C,
        ST_SU_A,
        ST_SU_B,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [LVL_W-1:0]  top_prio;
        logic              nonempty;
        logic [FILL_W-1:0] active_levels;
        t_err              error;
    } t_res;

endpackage

/* hw/rtl/psmh_res_reg.sv */
// Result holding register for the priority set max-heap output channel.
`timescale 1ns / 1ps

module psmh_res_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  psmh_pkg::t_res i_res,
    input  logic          i_stall,
    output logic          o_free,
    output logic          o_valid,
    output psmh_pkg::t_res o_res
);

    logic           r_valid;
    psmh_pkg::t_res r_res;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

/* hw/rtl/priority_set_max_heap.sv */
// Priority set kept as an indexed binary max-heap with per-level thread counts.
//
//   channel  dir  valid     stall     payload
//   request  in   i_valid   o_stall   i_op, i_prio
//   result   out  o_valid   i_stall   o_top_prio, o_nonempty, o_active_levels, o_error
//
// One request at a time; the heap memory has a single read port and sets the pace.
// Count-only requests go from the check straight to the result; a new level is placed
// at the end of the heap and sifted up. Removing the last thread of a level moves the
// last heap entry into the freed slot, unless nothing has to move, and sifts it down,
// then up. Reset is synchronous and clears the per-level valid bits. A stalled result
// is held while the next request runs.
`timescale 1ns / 1ps

module priority_set_max_heap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [7:0]  i_prio,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_top_prio,
    output logic        o_nonempty,
    output logic [8:0]  o_active_levels,
    output logic [1:0]  o_error
);

    localparam int LW = psmh_pkg::LVL_W;
    localparam int FW = psmh_pkg::FILL_W;
    localparam int CW = psmh_pkg::COUNT_BITS;
    localparam int NL = psmh_pkg::PRIO_LEVELS;

    // memories
    logic [LW-1:0] r_heap [NL];
    logic [LW-1:0] r_slot [NL];
    logic [CW-1:0] r_cnt  [NL];
    logic [NL-1:0] r_vld;

    psmh_pkg::t_state r_state, n_state;

    logic          r_op;
    logic [LW-1:0] r_prio;
    logic [FW-1:0] r_fill, n_fill;
    logic [LW-1:0] r_top, n_top;
    psmh_pkg::t_err r_err, n_err;
    logic [LW-1:0] r_lvl, n_lvl;
    logic [LW-1:0] r_pos, n_pos;
    logic [LW-1:0] r_s, n_s;
    logic [LW-1:0] r_sval, n_sval;
    logic [LW-1:0] r_ch, n_ch;
    logic [LW-1:0] r_heap_q;
    logic [LW-1:0] r_slot_q;
    logic [CW-1:0] r_cnt_q;
    logic          r_vld_q;

    logic          w_acc;
    logic [LW-1:0] w_rd_addr;
    logic          w_hp_we;
    logic [LW-1:0] w_hp_addr;
    logic [LW-1:0] w_hp_data;
    logic          w_cnt_we;
    logic [CW-1:0] w_cnt_data;

    logic [CW-1:0] w_cnt;
    logic [FW:0]   w_c;
    logic [FW:0]   w_c1;
    logic [FW:0]   w_fill_x;
    logic          w_has_c;
    logic          w_has_c1;
    logic [LW-1:0] w_parent;
    logic          w_sd_stop_b;
    logic          w_sd_stop_c;
    logic          w_b_gt_a;
    logic          w_up_move;
    logic          w_res_free;
    logic          w_res_load;
    psmh_pkg::t_res w_res;
    psmh_pkg::t_res w_res_q;

    assign o_stall = (r_state != psmh_pkg::ST_IDLE);
    assign w_acc   = i_valid && (r_state == psmh_pkg::ST_IDLE);

    assign w_cnt       = r_vld_q ? r_cnt_q : '0;
    assign w_c         = {1'b0, r_pos, 1'b1};
    assign w_c1        = w_c + (FW+1)'(1);
    assign w_fill_x    = {1'b0, r_fill};
    assign w_has_c     = (w_c < w_fill_x);
    assign w_has_c1    = (w_c1 < w_fill_x);
    assign w_parent    = LW'((r_pos - LW'(1)) >> 1);
    assign w_sd_stop_b = (r_lvl > r_heap_q);
    assign w_sd_stop_c = (r_lvl > r_ch) && (r_lvl > r_heap_q);
    assign w_b_gt_a    = (r_heap_q > r_ch);
    assign w_up_move   = (r_heap_q < r_lvl);
    assign w_res_load  = (r_state == psmh_pkg::ST_DONE) && w_res_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psmh_pkg::ST_IDLE: begin
                if (w_acc) n_state = psmh_pkg::ST_CHECK;
            end
            psmh_pkg::ST_CHECK: begin
                n_state = psmh_pkg::ST_DONE;
                if (!r_op) begin
                    if (w_cnt != psmh_pkg::COUNT_MAX && w_cnt == '0
                        && r_fill < FW'(NL)) begin
                        n_state = psmh_pkg::ST_SU_A;
                    end
                end else if (w_cnt == CW'(1)) begin
                    n_state = psmh_pkg::ST_LAST;
                end
            end
            psmh_pkg::ST_LAST: begin
                if (r_heap_q != r_prio && {1'b0, r_slot_q} < r_fill) begin
                    n_state = psmh_pkg::ST_SD_A;
                end else begin
                    n_state = psmh_pkg::ST_DONE;
                end
            end
            psmh_pkg::ST_SD_A: begin
                n_state = w_has_c ? psmh_pkg::ST_SD_B : psmh_pkg::ST_SU_A;
            end
            psmh_pkg::ST_SD_B: begin
                if (w_has_c1) begin
                    n_state = psmh_pkg::ST_SD_C;
                end else begin
                    n_state = w_sd_stop_b ? psmh_pkg::ST_SU_A : psmh_pkg::ST_SD_A;
                end
            end
            psmh_pkg::ST_SD_C: begin
                n_state = w_sd_stop_c ? psmh_pkg::ST_SU_A : psmh_pkg::ST_SD_A;
            end
            psmh_pkg::ST_SU_A: begin
                n_state = (r_pos == '0) ? psmh_pkg::ST_DONE : psmh_pkg::ST_SU_B;
            end
            psmh_pkg::ST_SU_B: begin
                n_state = w_up_move ? psmh_pkg::ST_SU_A : psmh_pkg::ST_DONE;
            end
            psmh_pkg::ST_DONE: begin
                if (w_res_free) n_state = psmh_pkg::ST_IDLE;
            end
            default: n_state = psmh_pkg::ST_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        n_fill     = r_fill;
        n_top      = r_top;
        n_err      = r_err;
        n_lvl      = r_lvl;
        n_pos      = r_pos;
        n_s        = r_s;
        n_sval     = r_sval;
        n_ch       = r_ch;
        w_rd_addr  = '0;
        w_hp_we    = 1'b0;
        w_hp_addr  = r_pos;
        w_hp_data  = r_lvl;
        w_cnt_we   = 1'b0;
        w_cnt_data = w_cnt;
        unique case (r_state)
            psmh_pkg::ST_IDLE: begin
                n_err = psmh_pkg::ERR_OK;
            end
            psmh_pkg::ST_CHECK: begin
                if (!r_op) begin
                    if (w_cnt == psmh_pkg::COUNT_MAX) begin
                        n_err = psmh_pkg::ERR_SAT;
                    end else begin
                        w_cnt_we   = 1'b1;
                        w_cnt_data = w_cnt + CW'(1);
                        if (w_cnt == '0 && r_fill < FW'(NL)) begin
                            n_fill = r_fill + FW'(1);
                            n_lvl  = r_prio;
                            n_pos  = r_fill[LW-1:0];
                        end
                    end
                end else begin
                    if (w_cnt == '0) begin
                        n_err = psmh_pkg::ERR_EMPTY;
                    end else begin
                        w_cnt_we   = 1'b1;
                        w_cnt_data = w_cnt - CW'(1);
                        if (w_cnt == CW'(1)) begin
                            n_fill    = r_fill - FW'(1);
                            w_rd_addr = LW'(r_fill - FW'(1));
                        end
                    end
                end
            end
            psmh_pkg::ST_LAST: begin
                n_lvl  = r_heap_q;
                n_pos  = r_slot_q;
                n_s    = r_slot_q;
                n_sval = r_heap_q;
            end
            psmh_pkg::ST_SD_A: begin
                if (w_has_c) begin
                    w_rd_addr = w_c[LW-1:0];
                end else begin
                    w_hp_we = 1'b1;
                    n_lvl   = (r_pos == r_s) ? r_lvl : r_sval;
                    n_pos   = r_s;
                end
            end
            psmh_pkg::ST_SD_B: begin
                n_ch = r_heap_q;
                if (w_has_c1) begin
                    w_rd_addr = w_c1[LW-1:0];
                end else if (w_sd_stop_b) begin
                    w_hp_we = 1'b1;
                    n_lvl   = (r_pos == r_s) ? r_lvl : r_sval;
                    n_pos   = r_s;
                end else begin
                    w_hp_we   = 1'b1;
                    w_hp_data = r_heap_q;
                    n_pos     = w_c[LW-1:0];
                    if (r_pos == r_s) n_sval = r_heap_q;
                end
            end
            psmh_pkg::ST_SD_C: begin
                w_hp_we = 1'b1;
                if (w_sd_stop_c) begin
                    n_lvl = (r_pos == r_s) ? r_lvl : r_sval;
                    n_pos = r_s;
                end else if (w_b_gt_a) begin
                    w_hp_data = r_heap_q;
                    n_pos     = w_c1[LW-1:0];
                    if (r_pos == r_s) n_sval = r_heap_q;
                end else begin
                    w_hp_data = r_ch;
                    n_pos     = w_c[LW-1:0];
                    if (r_pos == r_s) n_sval = r_ch;
                end
            end
            psmh_pkg::ST_SU_A: begin
                if (r_pos == '0) begin
                    w_hp_we = 1'b1;
                end else begin
                    w_rd_addr = w_parent;
                end
            end
            psmh_pkg::ST_SU_B: begin
                w_hp_we = 1'b1;
                if (w_up_move) begin
                    w_hp_data = r_heap_q;
                    n_pos     = w_parent;
                end
            end
            psmh_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
        if (w_hp_we && w_hp_addr == '0) n_top = w_hp_data;
    end

    // result
    always_comb begin
        w_res.nonempty      = (r_fill != '0);
        w_res.top_prio      = w_res.nonempty ? r_top : '0;
        w_res.active_levels = r_fill;
        w_res.error         = r_err;
    end

    psmh_res_reg u_res (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_load),
        .i_res   (w_res),
        .i_stall (i_stall),
        .o_free  (w_res_free),
        .o_valid (o_valid),
        .o_res   (w_res_q)
    );

    assign o_top_prio      = w_res_q.top_prio;
    assign o_nonempty      = w_res_q.nonempty;
    assign o_active_levels = w_res_q.active_levels;
    assign o_error         = w_res_q.error;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psmh_pkg::ST_IDLE;
            r_fill  <= '0;
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (w_cnt_we) r_vld[r_prio] <= (w_cnt_data != '0);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_top  <= n_top;
        r_err  <= n_err;
        r_lvl  <= n_lvl;
        r_pos  <= n_pos;
        r_s    <= n_s;
        r_sval <= n_sval;
        r_ch   <= n_ch;
        if (w_acc) begin
            r_op   <= i_op;
            r_prio <= i_prio;
        end
    end

    // heap memory
    always_ff @(posedge i_clk) begin
        if (w_hp_we) r_heap[w_hp_addr] <= w_hp_data;
        r_heap_q <= r_heap[w_rd_addr];
    end

    // slot-of-level memory
    always_ff @(posedge i_clk) begin
        if (w_hp_we) r_slot[w_hp_data] <= w_hp_addr;
        if (w_acc) r_slot_q <= r_slot[i_prio];
    end

    // thread count memory
    always_ff @(posedge i_clk) begin
        if (w_cnt_we) r_cnt[r_prio] <= w_cnt_data;
        if (w_acc) begin
            r_cnt_q <= r_cnt[i_prio];
            r_vld_q <= r_vld[i_prio];
        end
    end

endmodule
